FILE: rtl/bevel_span_generator_macros.svh
// assertion macros shared by the bevel span generator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef BEVEL_SPAN_GENERATOR_MACROS_SVH
`define BEVEL_SPAN_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bsg_pkg.sv
// types and helper functions for the bevel span generator
// no dependencies; used by all rtl modules of the block
`default_nettype none

package bsg_pkg;

   typedef enum logic [1:0] {
      SIDE_TOP    = 2'd0,
      SIDE_LEFT   = 2'd1,
      SIDE_BOTTOM = 2'd2,
      SIDE_RIGHT  = 2'd3
   } side_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PREP  = 4'b0010,
      ST_SPAN  = 4'b0100,
      ST_EMPTY = 4'b1000
   } state_type;

   // captured rectangle, bevel widths already clamped
   typedef struct packed {
      logic signed [12:0] rect_x;
      logic signed [12:0] rect_y;
      logic [11:0]        rect_w;
      logic [11:0]        rect_h;
      logic [3:0]         top_width;
      logic [3:0]         right_width;
      logic [3:0]         bottom_width;
      logic [3:0]         left_width;
      logic [23:0]        light_color;
      logic [23:0]        shadow_color;
   } item_type;

   // sequencer to datapath control
   typedef struct packed {
      logic     idle;
      logic     active;
      logic     empty;
      logic     last;
      side_type side;
      logic [3:0] step;
   } ctl_type;

   typedef struct packed {
      logic [13:0] span_x;
      logic [13:0] span_y;
      logic [11:0] span_width;
      logic [11:0] span_height;
      logic [23:0] span_color;
      logic        draw;
   } span_type;

   // first side with a nonzero width, top first
   function automatic side_type lowest_side(input logic [3:0] m);
      side_type s;
      priority if (m[0]) s = SIDE_TOP;
      else if (m[1])     s = SIDE_LEFT;
      else if (m[2])     s = SIDE_BOTTOM;
      else               s = SIDE_RIGHT;
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bsg_seq.sv
// sequencer walking sides and steps of one rectangle
// depends on bsg_pkg and bevel_span_generator_macros.svh
`default_nettype none
`include "bevel_span_generator_macros.svh"

module bsg_seq
   import bsg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     advance,
   input  wire item_type item,
   output      ctl_type  ctl
);

   state_type  state_ff, state_in;
   side_type   side_ff, side_in;
   logic [3:0] step_ff, step_in;
   logic [3:0] nz, later, cnt;
   logic       end_of_side, empty;

   assign nz = {item.right_width != 4'd0, item.bottom_width != 4'd0,
                item.left_width != 4'd0, item.top_width != 4'd0};
   assign empty = (item.rect_w == 12'd0) || (item.rect_h == 12'd0) || (nz == 4'd0);

   always_comb begin
      unique case (side_ff)
         SIDE_TOP: begin
            cnt   = item.top_width;
            later = nz & 4'b1110;
         end
         SIDE_LEFT: begin
            cnt   = item.left_width;
            later = nz & 4'b1100;
         end
         SIDE_BOTTOM: begin
            cnt   = item.bottom_width;
            later = nz & 4'b1000;
         end
         SIDE_RIGHT: begin
            cnt   = item.right_width;
            later = 4'd0;
         end
         default: begin
            cnt   = 4'd0;
            later = 4'd0;
         end
      endcase
   end

   assign end_of_side = (step_ff == cnt - 4'd1);

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_PREP;
         end
         ST_PREP: begin
            side_in = lowest_side(nz);
            step_in = 4'd0;
            state_in = empty ? ST_EMPTY : ST_SPAN;
         end
         ST_SPAN: begin
            if (advance) begin
               if (!end_of_side) begin
                  step_in = step_ff + 4'd1;
               end else if (later != 4'd0) begin
                  side_in = lowest_side(later);
                  step_in = 4'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            if (advance) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= SIDE_TOP;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         step_ff  <= step_in;
      end
   end

   assign ctl.idle   = (state_ff == ST_IDLE);
   assign ctl.active = (state_ff == ST_SPAN) || (state_ff == ST_EMPTY);
   assign ctl.empty  = (state_ff == ST_EMPTY);
   assign ctl.last   = (state_ff == ST_EMPTY) ||
                       ((state_ff == ST_SPAN) && end_of_side && (later == 4'd0));
   assign ctl.side   = side_ff;
   assign ctl.step   = step_ff;

   `BSG_ASSERT_IMPL(a_step_in_range, clock, reset, state_ff == ST_SPAN, step_ff < cnt, "step beyond side width")

endmodule

`default_nettype wire

FILE: rtl/bsg_span_unit.sv
// shared span datapath: position, length, color and draw flag of one bevel step
// depends on bsg_pkg
`default_nettype none

module bsg_span_unit
   import bsg_pkg::*;
(
   input  wire item_type   item,
   input  wire side_type   side,
   input  wire logic [3:0] step,
   output      span_type   span
);

   logic        row, flip, len_pos;
   logic [12:0] p, q;
   logic [11:0] e, f, len_sat;
   logic [3:0]  near_w, far_w, a, b;
   logic [13:0] along, cross_lo, cross_hi, cross_pos, len;

   assign row  = (side == SIDE_TOP) || (side == SIDE_BOTTOM);
   assign flip = (side == SIDE_BOTTOM) || (side == SIDE_RIGHT);

   // rows run along x, columns along y
   assign p      = row ? item.rect_x : item.rect_y;
   assign q      = row ? item.rect_y : item.rect_x;
   assign e      = row ? item.rect_w : item.rect_h;
   assign f      = row ? item.rect_h : item.rect_w;
   assign near_w = row ? item.left_width : item.top_width;
   assign far_w  = row ? item.right_width : item.bottom_width;

   // miter insets
   assign a = (step < near_w) ? step : near_w;
   assign b = (step < far_w) ? step : far_w;

   assign along     = {p[12], p} + {10'd0, a};
   assign cross_lo  = {q[12], q} + {10'd0, step};
   assign cross_hi  = {q[12], q} + {2'd0, f} - 14'd1 - {10'd0, step};
   assign cross_pos = flip ? cross_hi : cross_lo;

   assign len     = {2'd0, e} - {10'd0, a} - {10'd0, b};
   assign len_pos = !len[13] && (len != 14'd0);
   assign len_sat = len_pos ? len[11:0] : 12'd0;

   assign span.span_x      = row ? along : cross_pos;
   assign span.span_y      = row ? cross_pos : along;
   assign span.span_width  = row ? len_sat : 12'd1;
   assign span.span_height = row ? 12'd1 : len_sat;
   assign span.span_color  = flip ? item.shadow_color : item.light_color;
   assign span.draw        = len_pos && ({8'd0, step} < f);

endmodule

`default_nettype wire

FILE: rtl/bevel_span_generator.sv
// top level of the bevel span generator: stream ports, item capture, result register
// depends on bsg_pkg, bsg_seq, bsg_span_unit and bevel_span_generator_macros.svh
`default_nettype none
`include "bevel_span_generator_macros.svh"

// Draws the beveled border of a rectangle as one-pixel spans. Each item on req_
// gives a rectangle, four bevel widths (clamped to MAX_BEVEL) and a light and a
// shadow color; the block answers on rsp_ with one span per bevel row or column:
// top rows, left columns, bottom rows, right columns, each in ascending step
// order, with a staircase miter at the corners. Spans that end up empty or lie
// outside the rectangle still come out, with tuser (draw) low. An empty
// rectangle or all-zero widths gives a single all-zero result with draw low.
// tlast marks the final result of each item. After acceptance the sequencer
// passes a setup state, then steps the shared span unit once per cycle while
// the output register is free or drains (rsp_tready low holds it), and after
// the last step returns to idle, in which the block takes the next item.
// req_tready is low while an item is being worked on; the last result may
// still wait in the output register while the next item is accepted.

module bevel_span_generator
   import bsg_pkg::*;
#(
   parameter int MAX_BEVEL = 15
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // rect_x[12:0], rect_y[25:13], rect_w[37:26], rect_h[49:38], top_width[53:50],
   // right_width[57:54], bottom_width[61:58], left_width[65:62],
   // light_color[89:66], shadow_color[113:90], zero fill [119:114]
   input  wire logic [119:0] req_tdata,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // span_x[13:0], span_y[27:14], span_width[39:28], span_height[51:40],
   // span_color[75:52], zero fill [79:76]
   output      logic [79:0]  rsp_tdata,
   // draw
   output      logic         rsp_tuser,
   output      logic         rsp_tlast,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready
);

   localparam logic [3:0] MaxBevel = 4'(MAX_BEVEL);

   item_type    item_ff, item_in;
   ctl_type     ctl;
   span_type    span;
   logic        accept, advance;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        last_ff;
   span_type    out_ff;

   // clamp a bevel width to the configured maximum
   function automatic logic [3:0] clamp_w(input logic [3:0] v);
      return (v > MaxBevel) ? MaxBevel : v;
   endfunction

   assign accept = req_tvalid && req_tready;

   // unpack the incoming item
   always_comb begin
      item_in.rect_x       = req_tdata[12:0];
      item_in.rect_y       = req_tdata[25:13];
      item_in.rect_w       = req_tdata[37:26];
      item_in.rect_h       = req_tdata[49:38];
      item_in.top_width    = clamp_w(req_tdata[53:50]);
      item_in.right_width  = clamp_w(req_tdata[57:54]);
      item_in.bottom_width = clamp_w(req_tdata[61:58]);
      item_in.left_width   = clamp_w(req_tdata[65:62]);
      item_in.light_color  = req_tdata[89:66];
      item_in.shadow_color = req_tdata[113:90];
   end

   // item payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) item_ff <= item_in;
   end

   bsg_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .advance (advance),
      .item    (item_ff),
      .ctl     (ctl)
   );

   bsg_span_unit u_span (
      .item (item_ff),
      .side (ctl.side),
      .step (ctl.step),
      .span (span)
   );

   // a span moves into the output register when the register is free or drains
   assign advance      = ctl.active && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // empty rectangle gives an all-zero, non-drawn result
         out_ff  <= ctl.empty ? '0 : span;
         last_ff <= ctl.last;
      end
   end

   assign req_tready = ctl.idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.span_color, out_ff.span_height, out_ff.span_width,
                        out_ff.span_y, out_ff.span_x};
   assign rsp_tuser  = out_ff.draw;
   assign rsp_tlast  = last_ff;

   `BSG_ASSERT_NEXT(a_accept_busy, clock, reset, accept, !req_tready, "ready after accept")
   `BSG_ASSERT_IMPL(a_draw_nonempty, clock, reset, rsp_tvalid && rsp_tuser, (out_ff.span_width != 12'd0) && (out_ff.span_height != 12'd0), "drawn span with zero size")
   `BSG_ASSERT_NEXT(a_last_idle, clock, reset, advance && ctl.last, req_tready && rsp_tvalid && rsp_tlast, "last result did not end item")

endmodule

`default_nettype wire
